>>> rtl/core/sdm_pkg.sv
// Shared constants and types of the separable median disparity filter.
`default_nettype none

package sdm_pkg;

	// frame geometry that does not vary with the top-level parameters
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = 12;
	localparam int HGT_W      = 13;

	// configuration port
	localparam int CFG_WIDTH_BITS  = 12;
	localparam int CFG_HEIGHT_BITS = 13;
	localparam int CFG_DATA_BITS   = 13;
	localparam int CFG_INDEX_BITS  = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_WIDTH_BITS-1:0]  RESET_WIDTH  = 12'd640;
	localparam logic [CFG_HEIGHT_BITS-1:0] RESET_HEIGHT = 13'd480;

	// output queue (power of two so the pointers wrap by themselves)
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

	// per-word decisions handed from the position tracker to the datapath
	typedef struct packed {
		logic emit;     // word produces an output word
		logic have_h;   // a horizontal result exists for column hcol
		logic inner_h;  // horizontal median applies to that column
		logic inner_v;  // vertical median may apply to the emitted pixel
		logic last;     // emitted pixel closes the frame
	} sdm_item_t;

endpackage

`default_nettype wire

>>> rtl/core/sdm_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module sdm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/sdm_median.sv
// Rank-based median of N taps: compare matrix registered, then rank select.
`default_nettype none

module sdm_median #(
	parameter int N  = 7,
	parameter int VB = 16
) (
	input  logic                  clk,
	input  logic [N-1:0][VB-1:0]  taps,
	output logic [VB-1:0]         median
);

	localparam int MID   = (N - 1) / 2;
	localparam int CNT_W = $clog2(N);

	logic [N-1:0][N-1:0]  prec;
	logic [N-1:0][N-1:0]  prec_q;
	logic [N-1:0][VB-1:0] taps_q;
	logic [CNT_W-1:0]     rank [N];

	// prec[i][j]: tap j sorts ahead of tap i (ties broken by position)
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				if (j < i) begin
					prec[i][j] = $signed(taps[j]) <= $signed(taps[i]);
				end else if (j > i) begin
					prec[i][j] = $signed(taps[j]) < $signed(taps[i]);
				end else begin
					prec[i][j] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prec_q <= prec;
		taps_q <= taps;
	end

	// rank of each tap
	always_comb begin
		for (int i = 0; i < N; i++) begin
			rank[i] = '0;
			for (int j = 0; j < N; j++) begin
				rank[i] = rank[i] + CNT_W'(prec_q[i][j]);
			end
		end
	end

	// exactly one tap holds the middle rank
	always_comb begin
		median = '0;
		for (int i = 0; i < N; i++) begin
			if (rank[i] == CNT_W'(MID)) begin
				median = median | taps_q[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sdm_track.sv
// Raster position tracking, frame size registers and delay ring pointers.
`default_nettype none

module sdm_track #(
	parameter int MAX_WIDTH = 2048,
	parameter int RADIUS    = 3
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [sdm_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
	input  logic [sdm_pkg::CFG_DATA_BITS-1:0]             cfg_data,
	input  logic                                          accept,
	input  logic                                          flush,
	output sdm_pkg::sdm_item_t                            item,
	output logic [$clog2(MAX_WIDTH)-1:0]                  hcol,
	output logic [$clog2(RADIUS*MAX_WIDTH+RADIUS+1)-1:0]  delay_waddr,
	output logic [$clog2(RADIUS*MAX_WIDTH+RADIUS+1)-1:0]  delay_raddr
);

	import sdm_pkg::*;

	localparam int TAPS   = 2 * RADIUS + 1;
	localparam int DEPTH  = RADIUS * MAX_WIDTH + RADIUS + 1;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	function automatic logic [WID_W-1:0] sat_width(input logic [CFG_WIDTH_BITS-1:0] v);
		logic [WID_W-1:0] r;
		if (32'(v) < 32'(TAPS)) begin
			r = WID_W'(TAPS);
		end else if (32'(v) > 32'(MAX_WIDTH)) begin
			r = WID_W'(MAX_WIDTH);
		end else begin
			r = WID_W'(v);
		end
		return r;
	endfunction

	function automatic logic [HGT_W-1:0] sat_height(input logic [CFG_HEIGHT_BITS-1:0] v);
		logic [HGT_W-1:0] r;
		if (32'(v) < 32'(TAPS)) begin
			r = HGT_W'(TAPS);
		end else if (32'(v) > 32'(MAX_HEIGHT)) begin
			r = HGT_W'(MAX_HEIGHT);
		end else begin
			r = HGT_W'(v);
		end
		return r;
	endfunction

	logic [WID_W-1:0]  w_q;
	logic [HGT_W-1:0]  h_q;
	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [FILL_W-1:0] fill_q;
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;

	logic [FILL_W-1:0] lag;
	logic              have_h;
	logic              emit;
	logic              in_col_last, in_row_last, out_col_last, out_row_last;
	logic [PTR_W-1:0]  wr_next, rd_next;

	// output lag in words: RADIUS rows plus RADIUS pixels
	assign lag = FILL_W'(32'(RADIUS) * 32'(w_q) + 32'(RADIUS));

	assign have_h = 32'(in_col_q) >= 32'(RADIUS);
	assign hcol   = in_col_q - COL_W'(RADIUS);
	assign emit   = flush ? (fill_q != '0) : (fill_q >= lag);

	assign in_col_last  = 32'(in_col_q) == 32'(w_q) - 32'd1;
	assign in_row_last  = 32'(in_row_q) == 32'(h_q) - 32'd1;
	assign out_col_last = 32'(out_col_q) == 32'(w_q) - 32'd1;
	assign out_row_last = 32'(out_row_q) == 32'(h_q) - 32'd1;

	assign wr_next = (32'(wr_q) == 32'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
	assign rd_next = (32'(rd_q) == 32'(DEPTH - 1)) ? '0 : rd_q + 1'b1;

	// decisions for the word at the input
	always_comb begin
		item.emit    = emit;
		item.have_h  = !flush && have_h;
		item.inner_h = 32'(in_row_q) >= 32'(RADIUS) &&
			32'(in_row_q) + 32'(RADIUS) < 32'(h_q) &&
			32'(in_col_q) >= 32'(2 * RADIUS);
		item.inner_v = !flush && have_h && hcol == out_col_q &&
			32'(out_row_q) >= 32'(RADIUS) &&
			32'(out_row_q) + 32'(RADIUS) < 32'(h_q) &&
			32'(out_col_q) >= 32'(RADIUS) &&
			32'(out_col_q) + 32'(RADIUS) < 32'(w_q);
		item.last    = out_row_last && out_col_last;
	end

	assign delay_waddr = wr_q;
	assign delay_raddr = rd_q;

	// size registers, positions, fill count and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= sat_width(RESET_WIDTH);
			h_q       <= sat_height(RESET_HEIGHT);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fill_q    <= '0;
			wr_q      <= '0;
			rd_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					w_q <= sat_width(cfg_data[CFG_WIDTH_BITS-1:0]);
				end
				REG_FRAME_HEIGHT: begin
					h_q <= sat_height(cfg_data[CFG_HEIGHT_BITS-1:0]);
				end
				default: begin
				end
			endcase
			// any write restarts the frame
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fill_q    <= '0;
			wr_q      <= '0;
			rd_q      <= '0;
		end else if (accept) begin
			if (!flush) begin
				wr_q <= wr_next;
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_last ? '0 : in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (emit) begin
				rd_q <= rd_next;
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_last ? '0 : out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
			if (!flush && !emit) begin
				fill_q <= fill_q + 1'b1;
			end else if (flush && emit) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lag)
		else $error("pending count exceeds the output lag");

	a_ring_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_q >= rd_q) ? (32'(wr_q) - 32'(rd_q) == 32'(fill_q)) :
			(32'(wr_q) + 32'(DEPTH) - 32'(rd_q) == 32'(fill_q)))
		else $error("delay ring pointers disagree with pending count");

endmodule

`default_nettype wire

>>> rtl/core/sdm_outq.sv
// Output queue that decouples the filter pipeline from the result stream.
`default_nettype none

module sdm_outq #(
	parameter int WIDTH = 17
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [WIDTH-1:0]                push_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [WIDTH-1:0]                out_data,
	output logic [sdm_pkg::OUTQ_LVL_W-1:0]  level
);

	import sdm_pkg::*;

	logic [WIDTH-1:0]      store_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_q;
	logic [OUTQ_PTR_W-1:0] rd_q;
	logic [OUTQ_LVL_W-1:0] cnt_q;
	logic                  pop;

	assign out_valid = cnt_q != '0;
	assign out_data  = store_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign level     = cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_data;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != OUTQ_LVL_W'(OUTQ_DEPTH))
		else $error("output queue written while full");

endmodule

`default_nettype wire

>>> rtl/core/separable_median_disparity_filter_unit.sv
// Top level of the separable median disparity filter.
`default_nettype none

// Takes one disparity word per clock (signed fixed point, negative means
// invalid) in raster order and returns the filtered frame in raster order,
// one word per clock while the receiver is ready. Each word runs through
// a four-stage pipeline: a horizontal median over the row shift line, a
// read-modify-write of the per-column line memory holding the last
// 2*RADIUS horizontal results, a vertical median, and a small output
// queue; a result word passes through the stage registers and is then
// written into the queue. Results lag the input by RADIUS*width+RADIUS
// words, held in a delay ring memory; words with tuser set carry no pixel
// and each drain one pending word unfiltered. Input ready drops only when
// the output queue backs up. Both memories need no clearing pass after
// reset. A write to either size register restarts the frame and drops
// pending words; write it only while the block is idle.
module separable_median_disparity_filter_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int RADIUS     = 3,
	parameter int VALUE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sdm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [sdm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [VALUE_BITS-1:0] pixel_value, zero fill above
	input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// flush
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [VALUE_BITS-1:0] filtered_value, zero fill above
	output logic [((VALUE_BITS+7)/8)*8-1:0]     m_axis_tdata,
	// end_of_frame
	output logic                                m_axis_tlast
);

	import sdm_pkg::*;

	localparam int TAPS   = 2 * RADIUS + 1;
	localparam int LTAPS  = 2 * RADIUS;
	localparam int VB     = VALUE_BITS;
	localparam int DEPTH  = RADIUS * MAX_WIDTH + RADIUS + 1;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;

	logic                   accept;
	logic                   flush;
	logic [VB-1:0]          pix;
	sdm_item_t              item;
	logic [COL_W-1:0]       hcol;
	logic [PTR_W-1:0]       delay_waddr, delay_raddr;
	logic [VB-1:0]          delay_rdata;
	logic [LTAPS*VB-1:0]    line_rdata;

	logic [TAPS-1:0][VB-1:0]  row_window_q;
	logic [TAPS-1:0][VB-1:0]  window_next;

	logic                   valid_s1, valid_s2, valid_s3;
	sdm_item_t              item_s1, item_s2, item_s3;
	logic [COL_W-1:0]       hcol_s1, hcol_s2;
	logic [VB-1:0]          center_s1;
	logic [VB-1:0]          hmed;
	logic [VB-1:0]          hval;
	logic [VB-1:0]          hval_s2;
	logic [VB-1:0]          raw_s2, raw_s3;
	logic [LTAPS-1:0][VB-1:0] lines_s2;
	logic [LTAPS-1:0][VB-1:0] lines_new;
	logic [TAPS-1:0][VB-1:0]  vtaps;
	logic [VB-1:0]          vmed;
	logic [VB-1:0]          result;

	logic                   push;
	logic [VB:0]            q_data;
	logic [OUTQ_LVL_W-1:0]  q_level;
	logic [OUTQ_LVL_W:0]    inflight;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign flush  = s_axis_tuser;
	assign pix    = s_axis_tdata[VB-1:0];

	sdm_track #(
		.MAX_WIDTH (MAX_WIDTH),
		.RADIUS    (RADIUS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.flush       (flush),
		.item        (item),
		.hcol        (hcol),
		.delay_waddr (delay_waddr),
		.delay_raddr (delay_raddr)
	);

	// row shift line, newest pixel at the top tap
	always_comb begin
		for (int k = 0; k < TAPS - 1; k++) begin
			window_next[k] = row_window_q[k+1];
		end
		window_next[TAPS-1] = pix;
	end

	always_ff @(posedge clk) begin
		if (accept && !flush) begin
			row_window_q <= window_next;
		end
	end

	// horizontal median, result valid in stage 1
	sdm_median #(
		.N  (TAPS),
		.VB (VB)
	) u_hmed (
		.clk    (clk),
		.taps   (window_next),
		.median (hmed)
	);

	// raw pixels waiting for output
	sdm_ram #(
		.WIDTH (VB),
		.DEPTH (DEPTH)
	) u_delay_ram (
		.clk   (clk),
		.we    (accept && !flush),
		.waddr (delay_waddr),
		.wdata (pix),
		.raddr (delay_raddr),
		.rdata (delay_rdata)
	);

	// per-column history of horizontal results, oldest in the low slot
	sdm_ram #(
		.WIDTH (LTAPS * VB),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (valid_s2 && item_s2.have_h),
		.waddr (hcol_s2),
		.wdata (lines_new),
		.raddr (hcol),
		.rdata (line_rdata)
	);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		item_s1   <= item;
		hcol_s1   <= hcol;
		center_s1 <= window_next[RADIUS];
	end

	// horizontal result: median of valid interior centers, raw if invalid, zero outside the interior
	always_comb begin
		if (!item_s1.inner_h) begin
			hval = '0;
		end else if (!center_s1[VB-1]) begin
			hval = hmed;
		end else begin
			hval = center_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		item_s2  <= item_s1;
		hcol_s2  <= hcol_s1;
		hval_s2  <= hval;
		raw_s2   <= delay_rdata;
		lines_s2 <= line_rdata;
	end

	// column history shifted by one with the new result on top
	always_comb begin
		for (int k = 0; k < LTAPS - 1; k++) begin
			lines_new[k] = lines_s2[k+1];
		end
		lines_new[LTAPS-1] = hval_s2;
	end

	always_comb begin
		for (int k = 0; k < LTAPS; k++) begin
			vtaps[k] = lines_s2[k];
		end
		vtaps[TAPS-1] = hval_s2;
	end

	// vertical median, result valid in stage 3
	sdm_median #(
		.N  (TAPS),
		.VB (VB)
	) u_vmed (
		.clk    (clk),
		.taps   (vtaps),
		.median (vmed)
	);

	// stage 3 payload
	always_ff @(posedge clk) begin
		item_s3 <= item_s2;
		raw_s3  <= raw_s2;
	end

	assign result = (item_s3.inner_v && !raw_s3[VB-1]) ? vmed : raw_s3;
	assign push   = valid_s3 && item_s3.emit;

	sdm_outq #(
		.WIDTH (VB + 1)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({item_s3.last, result}),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (q_data),
		.level     (q_level)
	);

	assign m_axis_tdata = DATA_W'(q_data[VB-1:0]);
	assign m_axis_tlast = q_data[VB];

	// accept only while the queue can hold every word still in flight
	assign inflight = (OUTQ_LVL_W+1)'(valid_s1 && item_s1.emit) +
		(OUTQ_LVL_W+1)'(valid_s2 && item_s2.emit) +
		(OUTQ_LVL_W+1)'(valid_s3 && item_s3.emit);
	assign s_axis_tready = (OUTQ_LVL_W+1)'(q_level) + inflight <
		(OUTQ_LVL_W+1)'(OUTQ_DEPTH);

	// a column is revisited only a full row later, so no line read can
	// overlap a pending write-back of the same column
	a_line_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.have_h |->
			!(valid_s1 && item_s1.have_h && hcol_s1 == hcol) &&
			!(valid_s2 && item_s2.have_h && hcol_s2 == hcol))
		else $error("line memory read overlaps write-back of same column");

endmodule

`default_nettype wire

>>> tb/sv/tb_separable_median_disparity_filter_unit.sv
// Self-checking testbench for the separable median disparity filter unit.
`timescale 1ns / 100ps

module tb_separable_median_disparity_filter_unit;

	localparam int MAX_W      = 2048;
	localparam int RAD        = 3;
	localparam int TAPS       = 2 * RAD + 1;
	localparam int QUIET_MAX  = 4000;  // cycles with no word moving on either side
	localparam int HOLD_LEN   = 400;   // long receiver hold-off
	localparam int DRAIN_WAIT = 16;    // pipeline depth plus margin

	typedef logic signed [15:0] disp_t;
	typedef disp_t tap_set_t [TAPS];

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} filt_word_t;

	typedef struct packed {
		logic        flush;
		logic [15:0] data;
		logic        typed;      // expectation below is given, not predicted
		logic        has_res;
		logic [15:0] res_value;
		logic        res_last;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [sdm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [sdm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tlast;

	separable_median_disparity_filter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),   // [15:0] pixel_value
		.s_axis_tuser(s_axis_tuser),   // flush
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),   // [15:0] filtered_value
		.m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [11:0] reg_width = sdm_pkg::RESET_WIDTH;
	logic [12:0] reg_height = sdm_pkg::RESET_HEIGHT;
	tap_set_t row_win = '{default: '0};
	disp_t line_hist [MAX_W][2*RAD] = '{default: '{default: '0}};
	disp_t delay_line [$];
	int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

	filt_word_t expected_words [$];

	// run control and statistics
	int send_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int failures = 0;
	int words_in = 0, flushes_in = 0, words_out = 0, settings_done = 0;
	int quiet_cycles = 0;

	function automatic disp_t median7(input tap_set_t v);
		tap_set_t s;
		disp_t t;
		int i, j;
		for (i = 0; i < TAPS; i++) begin
			t = v[i];
			j = i - 1;
			while (j >= 0 && s[j] > t) begin
				s[j+1] = s[j];
				j--;
			end
			s[j+1] = t;
		end
		return s[RAD];
	endfunction

	function automatic int unsigned eff_width();
		int unsigned w;
		w = reg_width;
		if (w < TAPS) w = TAPS;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = reg_height;
		if (h < TAPS) h = TAPS;
		if (h > sdm_pkg::MAX_HEIGHT) h = sdm_pkg::MAX_HEIGHT;
		return h;
	endfunction

	// release the oldest pending pixel with the value given, advance output raster
	function automatic filt_word_t emit_word(input disp_t v, input int unsigned w, h);
		filt_word_t word;
		word.value = v;
		word.last = (out_row == h - 1 && out_col == w - 1);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) out_row = 0;
		end
		void'(delay_line.pop_front());
		return word;
	endfunction

	// one accepted input word through the filter; returns 1 when a result leaves
	function automatic bit filter_step(input bit fl, input logic [15:0] d,
			output filt_word_t res);
		int unsigned w, h, lag, hcol;
		disp_t pix, hval, outv;
		bit have_h, inner, releasing;
		tap_set_t taps;
		int i;
		w = eff_width();
		h = eff_height();
		lag = RAD * w + RAD;
		res = '0;
		have_h = 1'b0;
		hcol = 0;
		hval = '0;
		outv = '0;
		if (fl) begin
			if (delay_line.size() == 0) return 1'b0;
			res = emit_word(delay_line[0], w, h);
			return 1'b1;
		end
		pix = d;
		for (i = 0; i < TAPS - 1; i++) row_win[i] = row_win[i+1];
		row_win[TAPS-1] = pix;

		// horizontal median for the column RAD pixels back
		if (in_col >= RAD) begin
			hcol = in_col - RAD;
			inner = in_row >= RAD && in_row + RAD < h && hcol >= RAD;
			if (!inner) hval = '0;
			else if (row_win[RAD] >= 0) hval = median7(row_win);
			else hval = row_win[RAD];
			have_h = 1'b1;
		end
		delay_line.push_back(pix);
		releasing = delay_line.size() > lag;

		// vertical median over the column history plus the fresh value
		if (releasing) begin
			inner = out_row >= RAD && out_row + RAD < h && out_col >= RAD &&
				out_col + RAD < w && have_h && hcol == out_col;
			if (inner && delay_line[0] >= 0) begin
				for (i = 0; i < 2 * RAD; i++) taps[i] = line_hist[hcol][i];
				taps[2*RAD] = hval;
				outv = median7(taps);
			end else begin
				outv = delay_line[0];
			end
		end
		if (have_h) begin
			for (i = 0; i < 2 * RAD - 1; i++) line_hist[hcol][i] = line_hist[hcol][i+1];
			line_hist[hcol][2*RAD-1] = hval;
		end
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
			if (in_row >= h) in_row = 0;
		end
		if (releasing) begin
			res = emit_word(outv, w, h);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [15:0] random_disparity();
		logic [15:0] v;
		case ($urandom_range(19))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'h0000;
			3, 4, 5: v = {1'b1, 15'($urandom)};
			6, 7: v = {1'b0, 15'($urandom_range(255))};  // tight cluster
			default: v = {1'b0, 15'($urandom)};
		endcase
		return v;
	endfunction

	task automatic note_failure(input string what);
		failures++;
		if (failures <= 10) $display("ERROR: %s", what);
	endtask

	// offer one word, wait for the handshake, then queue its expectation
	task automatic send_word(input bit fl, input logic [15:0] d, input bit typed,
			input bit typed_has, input filt_word_t typed_res);
		filt_word_t pred;
		bit got;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fl;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_in++;
		if (fl) flushes_in++;
		got = filter_step(fl, d, pred);
		if (typed) begin
			if (typed_has) expected_words.push_back(typed_res);
		end else if (got) begin
			expected_words.push_back(pred);
		end
	endtask

	// both size registers; restarts the frame in the block and the predictor
	task automatic cfg_set(input logic [12:0] w_val, input logic [12:0] h_val);
		cfg_we <= 1'b1;
		cfg_index <= sdm_pkg::REG_FRAME_WIDTH;
		cfg_data <= w_val;
		@(posedge clk);
		reg_width = w_val[11:0];
		cfg_index <= sdm_pkg::REG_FRAME_HEIGHT;
		cfg_data <= h_val;
		@(posedge clk);
		reg_height = h_val;
		cfg_we <= 1'b0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		delay_line.delete();
		settings_done++;
	endtask

	task automatic wait_drained();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// one size setting: random frames, then flush words until nothing is pending
	task automatic run_phase(input logic [12:0] w_val, input logic [12:0] h_val,
			input int src_pct, input int dst_pct, input int n_pix, input int noise_pct,
			input bit pressure);
		int k;
		wait_drained();
		send_idle_pct = src_pct;
		rx_stall_pct = dst_pct;
		cfg_set(w_val, h_val);
		if (pressure) hold_requests++;
		for (k = 0; k < n_pix; k++) begin
			if ($urandom_range(99) < noise_pct) send_word(1'b1, 16'($urandom), 1'b0, 1'b0, '0);
			send_word(1'b0, random_disparity(), 1'b0, 1'b0, '0);
		end
		while (delay_line.size() != 0) send_word(1'b1, 16'($urandom), 1'b0, 1'b0, '0);
		repeat (2) send_word(1'b1, 16'($urandom), 1'b0, 1'b0, '0);
		s_axis_tvalid <= 1'b0;
	endtask

	// output side: check each word, then drive ready for the next edge
	always @(posedge clk) begin : rx_side
		filt_word_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			words_out++;
			if (expected_words.size() == 0) begin
				note_failure($sformatf("unexpected word %h last %b", m_axis_tdata,
					m_axis_tlast));
			end else begin
				want = expected_words.pop_front();
				if (m_axis_tdata !== want.value || m_axis_tlast !== want.last)
					note_failure($sformatf("word %0d: expected %h last %b, got %h last %b",
						words_out, want.value, want.last, m_axis_tdata, m_axis_tlast));
			end
		end
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_LEN;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// watchdog on cycles where no word moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == QUIET_MAX) begin
				$display("Timeout after %0d idle cycles", QUIET_MAX);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	dir_row_t directed_rows [14];

	initial begin : main
		filt_word_t typed_res;
		int r;
		// at reset size nothing is released until a flush drains it
		directed_rows = '{
			'{1'b1, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},  // flush, nothing pending
			'{1'b0, 16'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b0},  // still filling
			'{1'b0, 16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0},
			'{1'b0, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
			'{1'b0, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
			'{1'b0, 16'h0010, 1'b1, 1'b0, 16'h0000, 1'b0},
			'{1'b1, 16'hFFFF, 1'b1, 1'b1, 16'h7FFF, 1'b0},  // flush emits oldest raw
			'{1'b1, 16'h0000, 1'b1, 1'b1, 16'h8000, 1'b0},
			'{1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b0},
			'{1'b0, 16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0},
			'{1'b1, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0},
			'{1'b1, 16'h0000, 1'b1, 1'b1, 16'h0010, 1'b0},
			'{1'b1, 16'h5A5A, 1'b1, 1'b1, 16'h1234, 1'b0},
			'{1'b1, 16'hA5A5, 1'b1, 1'b0, 16'h0000, 1'b0}   // drained, no result
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < 14; r++) begin
			typed_res = '{directed_rows[r].res_value, directed_rows[r].res_last};
			send_word(directed_rows[r].flush, directed_rows[r].data, directed_rows[r].typed,
				directed_rows[r].has_res, typed_res);
		end
		s_axis_tvalid <= 1'b0;

		// smallest frame, then sizes below minimum, then mixed idling
		run_phase(13'd7, 13'd7, 0, 0, 49, 0, 1'b0);
		run_phase(13'd0, 13'd8, 81, 0, 40, 0, 1'b0);
		run_phase(13'd11, 13'd7, 0, 81, 80, 1, 1'b0);
		run_phase(13'd9, 13'd10, 11, 11, 70, 3, 1'b1);
		// widest line (register saturates) and tallest frame
		run_phase(13'h1FFF, 13'd3, 0, 0, 10, 0, 1'b0);
		run_phase(13'd7, 13'h1FFF, 40, 40, 24, 0, 1'b0);

		wait_drained();
		if (expected_words.size() != 0)
			note_failure($sformatf("%0d expected words never arrived", expected_words.size()));
		$display("Sent %0d words (%0d flushes) over %0d size settings, checked %0d results",
			words_in, flushes_in, settings_done, words_out);
		$display("Mismatches: %0d", failures);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
